@@ hdl/slt_pkg.sv @@
`timescale 1ns / 1ps

package slt_pkg;

    localparam int unsigned MAX_RESULTS = 4;

    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_END    = 3'd1;
    localparam logic [2:0] KIND_OK     = 3'd2;
    localparam logic [2:0] KIND_ESCAPE = 3'd3;
    localparam logic [2:0] KIND_QUOTE  = 3'd4;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_BAR  = 2'd1;
    localparam logic [1:0] OP_AMP  = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_t;

    // results of one input transaction
    typedef struct packed {
        logic [2:0]                   count;
        out_t [MAX_RESULTS-1:0]       items;
    } batch_t;

    function automatic logic [7:0] op_char(input logic [1:0] op);
        logic [7:0] ch;
        case (op)
            OP_BAR:  ch = CH_BAR;
            OP_AMP:  ch = CH_AMP;
            OP_GT:   ch = CH_GT;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic out_t make_res(input logic [2:0] kind, input logic [7:0] b);
        out_t r;
        r.kind        = kind;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/shell_line_tokenizer_top.sv @@
`timescale 1ns / 1ps

// Channel  Signals                             Direction  Payload
// item     item_valid, item_stall, item        in         char_byte, line_end
// result   result_valid, result_stall, result  out        kind, out_byte, last_of_run
//
// An accepted item is held in the input register, then the tokenizer
// logic turns it into zero to four results in the result buffer.
// Results leave one per cycle while result_stall is low.
// Reset clears the quoting, escape, token and pending-operator state.
// item_stall rises while the input register holds a transaction and the
// result buffer is not emptied in that cycle.

module shell_line_tokenizer_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  slt_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output slt_pkg::out_t result
);

    logic            in_valid_reg;
    slt_pkg::in_t    in_item_reg;
    logic            free;
    logic            advance;
    slt_pkg::batch_t batch;

    assign advance    = in_valid_reg && free;
    assign item_stall = in_valid_reg && !free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    slt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .batch   (batch)
    );

    slt_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && (batch.count != 3'd0)),
        .batch        (batch),
        .free         (free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ hdl/slt_core.sv @@
`timescale 1ns / 1ps

module slt_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  slt_pkg::in_t    item,
    output slt_pkg::batch_t batch
);

    logic       sq_reg, sq_next;
    logic       dq_reg, dq_next;
    logic       esc_reg, esc_next;
    logic       wo_reg, wo_next;
    logic [1:0] op_reg, op_next;

    slt_pkg::out_t [slt_pkg::MAX_RESULTS-1:0] res;
    logic [2:0] n;
    logic [7:0] c;
    logic       is_space;
    logic       op_match;

    always_comb
    begin
        sq_next  = sq_reg;
        dq_next  = dq_reg;
        esc_next = esc_reg;
        wo_next  = wo_reg;
        op_next  = slt_pkg::OP_NONE;
        res      = '0;
        n        = 3'd0;
        c        = item.char_byte;
        is_space = c inside {slt_pkg::CH_SPACE, [slt_pkg::CH_TAB:slt_pkg::CH_CR]};
        op_match = (op_reg != slt_pkg::OP_NONE) && (c == slt_pkg::op_char(op_reg));

        if (!item.line_end && op_match)
        begin
            if (op_reg == slt_pkg::OP_AMP && wo_reg)
            begin
                res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_END, 8'h00);
                n = n + 3'd1;
            end
            res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_BYTE, c);
            n = n + 3'd1;
            res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_BYTE, c);
            n = n + 3'd1;
            res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_END, 8'h00);
            n = n + 3'd1;
            wo_next = 1'b0;
        end
        else
        begin
            // unmatched pending operator
            if (op_reg == slt_pkg::OP_AMP)
            begin
                res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_BYTE, slt_pkg::CH_AMP);
                n = n + 3'd1;
                wo_next = 1'b1;
            end
            else if (op_reg != slt_pkg::OP_NONE)
            begin
                res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_BYTE,
                                                slt_pkg::op_char(op_reg));
                n = n + 3'd1;
                res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_END, 8'h00);
                n = n + 3'd1;
            end

            if (item.line_end)
            begin
                if (esc_reg)
                begin
                    res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_ESCAPE, 8'h00);
                    n = n + 3'd1;
                end
                else if (sq_reg || dq_reg)
                begin
                    res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_QUOTE, 8'h00);
                    n = n + 3'd1;
                end
                else
                begin
                    if (wo_next)
                    begin
                        res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_END, 8'h00);
                        n = n + 3'd1;
                    end
                    res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_OK, 8'h00);
                    n = n + 3'd1;
                end
                sq_next  = 1'b0;
                dq_next  = 1'b0;
                esc_next = 1'b0;
                wo_next  = 1'b0;
            end
            else if (esc_reg)
            begin
                res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_BYTE, c);
                n = n + 3'd1;
                wo_next  = 1'b1;
                esc_next = 1'b0;
            end
            else if (!sq_reg && c == slt_pkg::CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (!sq_reg && c == slt_pkg::CH_DQUOTE)
            begin
                dq_next = ~dq_reg;
            end
            else if (!dq_reg && c == slt_pkg::CH_SQUOTE)
            begin
                sq_next = ~sq_reg;
            end
            else if (!sq_reg && !dq_reg && (is_space || c == slt_pkg::CH_BAR ||
                                            c == slt_pkg::CH_GT))
            begin
                if (wo_next)
                begin
                    res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_END, 8'h00);
                    n = n + 3'd1;
                end
                wo_next = 1'b0;
                if (c == slt_pkg::CH_BAR)
                begin
                    op_next = slt_pkg::OP_BAR;
                end
                else if (c == slt_pkg::CH_GT)
                begin
                    op_next = slt_pkg::OP_GT;
                end
            end
            else if (!sq_reg && !dq_reg && c == slt_pkg::CH_AMP)
            begin
                op_next = slt_pkg::OP_AMP;
            end
            else
            begin
                res[n[1:0]] = slt_pkg::make_res(slt_pkg::KIND_BYTE, c);
                n = n + 3'd1;
                wo_next = 1'b1;
            end
        end

        for (int i = 0; i < slt_pkg::MAX_RESULTS; i++)
        begin
            res[i].last_of_run = (n != 3'd0) && (3'(i) == n - 3'd1);
        end
    end

    assign batch.count = n;
    assign batch.items = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg  <= 1'b0;
            dq_reg  <= 1'b0;
            esc_reg <= 1'b0;
            wo_reg  <= 1'b0;
            op_reg  <= slt_pkg::OP_NONE;
        end
        else if (advance)
        begin
            sq_reg  <= sq_next;
            dq_reg  <= dq_next;
            esc_reg <= esc_next;
            wo_reg  <= wo_next;
            op_reg  <= op_next;
        end
    end

endmodule

@@ hdl/slt_drain.sv @@
`timescale 1ns / 1ps

module slt_drain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  slt_pkg::batch_t batch,
    output logic            free,
    output logic            result_valid,
    input  logic            result_stall,
    output slt_pkg::out_t   result
);

    slt_pkg::out_t [slt_pkg::MAX_RESULTS-1:0] items_reg;
    logic [2:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;
    logic       pop;
    logic       pop_last;

    assign result_valid = (count_reg != 3'd0);
    assign result       = items_reg[idx_reg];
    assign pop          = result_valid && !result_stall;
    assign pop_last     = pop && ({1'b0, idx_reg} == count_reg - 3'd1);
    assign free         = (count_reg == 3'd0) || pop_last;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = batch.count;
            idx_next   = 2'd0;
        end
        else if (pop_last)
        begin
            count_next = 3'd0;
            idx_next   = 2'd0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            items_reg <= batch.items;
        end
    end

endmodule
